>>> rtl/core/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

	localparam int VALUE_W  = 10;
	localparam int LETTER_W = 5;
	localparam int LETTER_N = 2 ** LETTER_W;

	// Alphabet size limits and reset value
	localparam logic [LETTER_W-1:0] ALPHA_MIN   = 5'd2;
	localparam logic [LETTER_W-1:0] ALPHA_MAX   = 5'd26;
	localparam logic [LETTER_W-1:0] ALPHA_RESET = 5'd26;

	typedef struct packed {
		logic [VALUE_W-1:0] prefix_value;
		logic               start_of_string;
	} in_item_t;

	typedef struct packed {
		logic [LETTER_W-1:0] letter_index;
		logic                error_flag;
	} out_item_t;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_COPY = 6'b000010,
		S_HEAD = 6'b000100,
		S_WALK = 6'b001000,
		S_PICK = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

>>> rtl/core/sfp_ram.sv
`timescale 1ns / 1ps

module sfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/core/string_from_prefix_function.sv
`timescale 1ns / 1ps

// String from prefix function.
// Input channel (in_valid/in_ready/in_item) takes one prefix-function value per
// item; start_of_string restarts the position at zero. Output channel
// (out_valid/out_ready/out_item) gives one item per input item: the letter
// index of the smallest string with that prefix function, or error_flag with
// letter 0 when the value exceeds the position, no letter is free, or the
// string already holds MAX_LEN letters. A rejected item is not stored.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes the alphabet size; write
// it only while no item is in flight. Sizes below 2 act as 2, above 26 as 26.
// Per item: an error or the first position goes straight to the final state, a
// nonzero value takes one letter-store read, and a zero value walks the
// failure chain, where each link is one read of the value and letter stores.
// One item is worked on at a time.
// A finished item sits in the output register; the next item is accepted
// while it waits, and the block holds in its final state until the register
// frees up. Reset clears position and sets the alphabet size to 26; both stores
// are left unwritten and only entries of the current string are used.
module string_from_prefix_function #(
	parameter int MAX_LEN = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  sfp_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output sfp_pkg::out_item_t          out_item,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sfp_pkg::LETTER_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int PW = $clog2(MAX_LEN + 1);
	localparam int CW = (PW > sfp_pkg::VALUE_W) ? PW : sfp_pkg::VALUE_W;

	sfp_pkg::state_t state_q;

	logic [sfp_pkg::LETTER_W-1:0] alpha_q;
	logic [sfp_pkg::LETTER_W-1:0] size_eff;
	logic [PW-1:0]                pos_q;
	logic [PW-1:0]                pos_eff;
	logic [PW-1:0]                pos_m1;
	logic [sfp_pkg::VALUE_W-1:0]  v_q;
	logic [sfp_pkg::VALUE_W-1:0]  j_q;
	logic [sfp_pkg::VALUE_W-1:0]  v_m1;
	logic [sfp_pkg::VALUE_W-1:0]  val_m1;
	logic [sfp_pkg::LETTER_N-1:0] used_q;
	logic [sfp_pkg::LETTER_W-1:0] letter_q;
	logic                         err_q;
	logic                         out_valid_q;
	sfp_pkg::out_item_t           out_item_q;

	logic                         accept;
	logic                         range_err;
	logic                         out_free;
	logic                         store_wr;
	logic                         chain_more;
	logic                         head_more;
	logic                         pick_found;
	logic [sfp_pkg::LETTER_W-1:0] pick_letter;

	logic [AW-1:0]                val_rd_addr;
	logic [AW-1:0]                let_rd_addr;
	logic [sfp_pkg::VALUE_W-1:0]  val_rd;
	logic [sfp_pkg::LETTER_W-1:0] let_rd;

	// Configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= sfp_pkg::ALPHA_RESET;
		end else if (cfg_valid) begin
			alpha_q <= cfg_data;
		end
	end

	// Clamp alphabet size
	always_comb begin
		if (alpha_q < sfp_pkg::ALPHA_MIN) begin
			size_eff = sfp_pkg::ALPHA_MIN;
		end else if (alpha_q > sfp_pkg::ALPHA_MAX) begin
			size_eff = sfp_pkg::ALPHA_MAX;
		end else begin
			size_eff = alpha_q;
		end
	end

	// Accept decode
	assign in_ready  = (state_q == sfp_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign pos_eff   = in_item.start_of_string ? '0 : pos_q;
	assign pos_m1    = pos_eff - PW'(1);
	assign v_m1      = in_item.prefix_value - sfp_pkg::VALUE_W'(1);
	assign range_err = (CW'(pos_eff) >= CW'(MAX_LEN)) ||
	                   (CW'(in_item.prefix_value) > CW'(pos_eff));

	// Chain walk decode: value read gives the next link
	assign val_m1     = val_rd - sfp_pkg::VALUE_W'(1);
	assign head_more  = (val_rd != '0) && (CW'(val_rd) < CW'(pos_q));
	assign chain_more = (val_rd != '0) && (val_rd < j_q);

	// Store read addresses: prior string entry on accept, chain link afterwards
	always_comb begin
		if (state_q == sfp_pkg::S_IDLE) begin
			val_rd_addr = AW'(pos_m1);
			let_rd_addr = AW'(v_m1);
		end else begin
			val_rd_addr = AW'(val_m1);
			let_rd_addr = AW'(val_rd);
		end
	end

	// Smallest free letter above zero
	always_comb begin
		pick_found  = 1'b0;
		pick_letter = '0;
		for (int c = sfp_pkg::LETTER_N - 1; c >= 1; c--) begin
			if ((sfp_pkg::LETTER_W'(c) < size_eff) && !used_q[c]) begin
				pick_found  = 1'b1;
				pick_letter = sfp_pkg::LETTER_W'(c);
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign store_wr = (state_q == sfp_pkg::S_DONE) && out_free && !err_q;

	// Sequencer; stores are written only in the final state and read after
	// the next accept, so no access to one entry can overlap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfp_pkg::S_IDLE;
			pos_q   <= '0;
		end else begin
			case (state_q)
				sfp_pkg::S_IDLE: begin
					if (accept) begin
						pos_q <= pos_eff;
						if (range_err || (pos_eff == '0)) begin
							state_q <= sfp_pkg::S_DONE;
						end else if (in_item.prefix_value != '0) begin
							state_q <= sfp_pkg::S_COPY;
						end else begin
							state_q <= sfp_pkg::S_HEAD;
						end
					end
				end
				sfp_pkg::S_COPY: begin
					state_q <= sfp_pkg::S_DONE;
				end
				sfp_pkg::S_HEAD: begin
					state_q <= head_more ? sfp_pkg::S_WALK : sfp_pkg::S_PICK;
				end
				sfp_pkg::S_WALK: begin
					if (!chain_more) begin
						state_q <= sfp_pkg::S_PICK;
					end
				end
				sfp_pkg::S_PICK: begin
					state_q <= sfp_pkg::S_DONE;
				end
				sfp_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= sfp_pkg::S_IDLE;
						if (!err_q) begin
							pos_q <= pos_q + PW'(1);
						end
					end
				end
				default: begin
					state_q <= sfp_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the item in flight
	always_ff @(posedge clk) begin
		case (state_q)
			sfp_pkg::S_IDLE: begin
				v_q      <= in_item.prefix_value;
				used_q   <= '0;
				letter_q <= '0;
				err_q    <= range_err;
			end
			sfp_pkg::S_COPY: begin
				letter_q <= let_rd;
			end
			sfp_pkg::S_HEAD: begin
				j_q <= val_rd;
			end
			sfp_pkg::S_WALK: begin
				used_q <= used_q | (sfp_pkg::LETTER_N'(1) << let_rd);
				j_q    <= val_rd;
			end
			sfp_pkg::S_PICK: begin
				letter_q <= pick_letter;
				err_q    <= !pick_found;
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	// Value store
	sfp_ram #(
		.WIDTH(sfp_pkg::VALUE_W),
		.DEPTH(MAX_LEN)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (AW'(pos_q)),
		.wr_data (v_q),
		.rd_addr (val_rd_addr),
		.rd_data (val_rd)
	);

	// Letter store
	sfp_ram #(
		.WIDTH(sfp_pkg::LETTER_W),
		.DEPTH(MAX_LEN)
	) u_let_ram (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (AW'(pos_q)),
		.wr_data (letter_q),
		.rd_addr (let_rd_addr),
		.rd_data (let_rd)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == sfp_pkg::S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == sfp_pkg::S_DONE) && out_free) begin
			out_item_q.letter_index <= err_q ? '0 : letter_q;
			out_item_q.error_flag   <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Checks
	a_err_letter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_item_q.error_flag |-> out_item_q.letter_index == '0)
		else $error("error item carries nonzero letter");

	a_pick_in_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfp_pkg::S_PICK) && pick_found
		|-> (pick_letter != '0) && (pick_letter < size_eff))
		else $error("picked letter outside alphabet");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(pos_q) <= CW'(MAX_LEN))
		else $error("position beyond store depth");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != sfp_pkg::S_IDLE)
		else $error("accepted item not started");

	a_chain_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfp_pkg::S_WALK) && ($past(state_q) == sfp_pkg::S_WALK)
		|-> j_q < $past(j_q))
		else $error("failure chain does not descend");

endmodule

>>> sim/string_from_prefix_function_test.sv
`timescale 1ns / 1ps

module string_from_prefix_function_test;

	localparam int STORE_DEPTH = 1024;
	localparam int MAX_STR     = 300;
	localparam int CYCLE_LIMIT = 1000000;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_ready;
	sfp_pkg::in_item_t            in_item   = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	sfp_pkg::out_item_t           out_item;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [sfp_pkg::LETTER_W-1:0] cfg_data  = '0;

	// Predictor state: alphabet register, value and letter stores, string position
	logic [sfp_pkg::LETTER_W-1:0] alpha_size = sfp_pkg::ALPHA_RESET;
	logic [sfp_pkg::VALUE_W-1:0]  seen_value  [STORE_DEPTH];
	logic [sfp_pkg::LETTER_W-1:0] seen_letter [STORE_DEPTH];
	int                           str_pos = 0;

	sfp_pkg::out_item_t pending_letters[$];
	int                 mismatches    = 0;
	int                 items_sent    = 0;
	int                 cycle_count   = 0;
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 hold_left     = 0;

	string_from_prefix_function #(
		.MAX_LEN(STORE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Drive the receiver: long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Compare each delivered item with the oldest pending letter
	always @(posedge clk) begin : check_results
		sfp_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_letters.size() == 0) begin
				report_mismatch($sformatf("unexpected item letter %0d err %0b",
					out_item.letter_index, out_item.error_flag));
			end else begin
				want = pending_letters.pop_front();
				if (out_item.letter_index !== want.letter_index)
					report_mismatch($sformatf("letter_index got %0d, expected %0d",
						out_item.letter_index, want.letter_index));
				if (out_item.error_flag !== want.error_flag)
					report_mismatch($sformatf("error_flag got %0b, expected %0b",
						out_item.error_flag, want.error_flag));
			end
		end
	end

	// Choose the letter for one value and advance the string
	function automatic sfp_pkg::out_item_t choose_letter(input sfp_pkg::in_item_t item);
		sfp_pkg::out_item_t           res;
		int                           size;
		int                           j;
		int                           nxt;
		int                           hops;
		int                           c;
		logic [sfp_pkg::LETTER_N-1:0] used;
		logic                         bad;
		res  = '0;
		bad  = 1'b0;
		used = '0;
		size = int'(alpha_size);
		if (alpha_size < sfp_pkg::ALPHA_MIN)
			size = int'(sfp_pkg::ALPHA_MIN);
		else if (alpha_size > sfp_pkg::ALPHA_MAX)
			size = int'(sfp_pkg::ALPHA_MAX);
		if (item.start_of_string)
			str_pos = 0;
		if (str_pos >= STORE_DEPTH || int'(item.prefix_value) > str_pos) begin
			bad = 1'b1;
		end else if (str_pos == 0) begin
			res.letter_index = '0;
		end else if (item.prefix_value != 0) begin
			res.letter_index = seen_letter[item.prefix_value - 1];
		end else begin
			// walk the failure chain and mark the letters that would extend it
			j    = int'(seen_value[str_pos - 1]);
			hops = 0;
			while (j > 0 && j < str_pos && hops < STORE_DEPTH) begin
				used[seen_letter[j]] = 1'b1;
				nxt = int'(seen_value[j - 1]);
				if (nxt >= j)
					break;
				j = nxt;
				hops++;
			end
			bad = 1'b1;
			for (c = 1; c < size; c++) begin
				if (!used[c]) begin
					res.letter_index = sfp_pkg::LETTER_W'(c);
					bad = 1'b0;
					break;
				end
			end
		end
		if (bad) begin
			res.letter_index = '0;
			res.error_flag   = 1'b1;
		end else begin
			seen_value[str_pos]  = item.prefix_value;
			seen_letter[str_pos] = res.letter_index;
			str_pos++;
		end
		return res;
	endfunction

	// Offer one item; called and returns at a falling edge
	task automatic send_item(input logic [sfp_pkg::VALUE_W-1:0] value, input logic start);
		sfp_pkg::in_item_t  item;
		sfp_pkg::out_item_t want;
		item.prefix_value    = value;
		item.start_of_string = start;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item  <= item;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = choose_letter(item);
		pending_letters.insert(pending_letters.size(), want);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_letters.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_alphabet(input logic [sfp_pkg::LETTER_W-1:0] size);
		cfg_data  <= size;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		alpha_size = size;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		@(negedge clk);
	endtask

	// Send the prefix function of a random, mostly periodic string
	task automatic send_random_string();
		int text     [MAX_STR];
		int fail_len [MAX_STR];
		int len;
		int kinds;
		int period;
		int i;
		int k;
		int r;
		logic [sfp_pkg::VALUE_W-1:0] value;
		logic                        start;
		len    = ($urandom_range(99) < 4) ? $urandom_range(100, MAX_STR) : $urandom_range(1, 40);
		kinds  = ($urandom_range(9) == 0) ? $urandom_range(5, 26) : $urandom_range(1, 3);
		period = $urandom_range(1, 8);
		for (i = 0; i < len; i++) begin
			if (i < period || $urandom_range(9) == 0)
				text[i] = $urandom_range(kinds - 1);
			else
				text[i] = text[i - period];
		end
		fail_len[0] = 0;
		for (i = 1; i < len; i++) begin
			k = fail_len[i - 1];
			while (k > 0 && text[i] != text[k])
				k = fail_len[k - 1];
			if (text[i] == text[k])
				k++;
			fail_len[i] = k;
		end
		for (i = 0; i < len; i++) begin
			value = sfp_pkg::VALUE_W'(fail_len[i]);
			start = (i == 0);
			r = $urandom_range(99);
			// corrupt a few values: wild, or plausible but inconsistent
			if (r < 4)
				value = sfp_pkg::VALUE_W'($urandom_range(1023));
			else if (r < 8)
				value = sfp_pkg::VALUE_W'($urandom_range(0, i + 1));
			// drop the start mark now and then, or restart mid-string
			if (i == 0 && $urandom_range(19) == 0)
				start = 1'b0;
			else if (i > 0 && $urandom_range(49) == 0)
				start = 1'b1;
			send_item(value, start);
		end
	endtask

	task automatic test_directed_cases();
		set_idling(10, 30);
		// no start mark after reset: the first item is position 0
		send_item(10'd0, 1'b0);
		send_item(10'd1, 1'b0);
		send_item(10'd3, 1'b0);
		send_item(10'd0, 1'b0);
		send_item(10'd1023, 1'b0);
		send_item(10'd512, 1'b1);
		send_item(10'd1, 1'b1);
		send_item(10'd0, 1'b1);
		send_item(10'd0, 1'b0);
		send_item(10'd1, 1'b0);
		send_item(10'd0, 1'b0);
		send_item(10'd682, 1'b0);
		send_item(10'd341, 1'b0);
		drain_results();
		// two letters: after "aba" a zero value finds no free letter
		write_alphabet(sfp_pkg::ALPHA_MIN);
		send_item(10'd0, 1'b1);
		send_item(10'd0, 1'b0);
		send_item(10'd1, 1'b0);
		send_item(10'd0, 1'b0);
		// rejected item leaves the position where it was
		send_item(10'd3, 1'b0);
		send_item(10'd0, 1'b0);
		drain_results();
	endtask

	// Climb through every letter: each zero value sees all lower letters on its chain
	task automatic send_letter_ladder();
		int k;
		send_item(10'd0, 1'b1);
		send_item(10'd0, 1'b0);
		for (k = 1; k <= 26; k++) begin
			send_item(10'd0, 1'b0);
			send_item(sfp_pkg::VALUE_W'(2 * k), 1'b0);
		end
	endtask

	task automatic test_letter_ladder();
		logic [sfp_pkg::LETTER_W-1:0] sizes[3];
		int n;
		sizes = '{5'd31, 5'd0, 5'($urandom_range(3, 25))};
		set_idling(20, 20);
		for (n = 0; n < 3; n++) begin
			drain_results();
			write_alphabet(sizes[n]);
			send_letter_ladder();
		end
		drain_results();
	endtask

	// Fill the store with copies of letter 0, then overflow it
	task automatic test_store_full();
		int p;
		set_idling(5, 5);
		send_item(10'd0, 1'b1);
		for (p = 1; p < STORE_DEPTH; p++)
			send_item(sfp_pkg::VALUE_W'(p), 1'b0);
		send_item(10'd0, 1'b0);
		send_item(10'd1023, 1'b0);
		send_item(10'd0, 1'b1);
		send_item(10'd1, 1'b0);
		drain_results();
	endtask

	// Hold the receiver off while items keep coming, so the input stalls
	task automatic test_output_stall();
		int first;
		set_idling(0, 0);
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		first = items_sent;
		while (items_sent - first < 40)
			send_random_string();
		drain_results();
	endtask

	task automatic run_random_phase(input int send_pct, input int recv_pct);
		int first;
		drain_results();
		if ($urandom_range(3) == 0)
			write_alphabet(5'($urandom_range(0, 31)));
		else
			write_alphabet(5'($urandom_range(3, 26)));
		set_idling(send_pct, recv_pct);
		first = items_sent;
		while (items_sent - first < 40)
			send_random_string();
		drain_results();
	endtask

	task automatic test_random_traffic();
		run_random_phase(13, 67);
		run_random_phase(67, 13);
		run_random_phase(0, 0);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_letter_ladder();
		test_store_full();
		test_output_stall();
		test_random_traffic();
		drain_results();
		// allow a stray late item to show up
		repeat (64) @(negedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
